### hw/rtl/tbbp_pkg.sv
// Shared widths, register indexes, unit opcodes and control structs of the burst profiler.
`default_nettype none

package tbbp_pkg;

  localparam int TIME_W  = 48;  // arrival timestamp, ticks
  localparam int WORK_W  = 32;  // work per entry, integer units
  localparam int RATE_W  = 32;  // drain rate, Q16.16
  localparam int FRAC_W  = 16;  // fraction bits of rates and levels
  localparam int LVL_W   = 64;  // bucket level and peak, Q48.16
  localparam int CNT_W   = 5;   // rate count register
  localparam int RIDX_W  = 4;   // reported rate index
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MAX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_COUNT = 2'd2;

  localparam logic [RATE_W-1:0] RATE_MAX_RST   = 32'd65536;
  localparam logic [RATE_W-1:0] RATE_STEP_RST  = 32'd66;
  localparam logic [CNT_W-1:0]  RATE_COUNT_RST = 5'd16;

  // Operations of the shared arithmetic unit.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ELAPSED,
    OP_RATE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_AMOUNT,
    OP_DRAIN,
    OP_FILL_PEAK
  } alu_op_t;

  // Control of the bucket and peak store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mem_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/tbbp_alu.sv
// Shared multiply and add/subtract unit that drains, fills and compares one bucket per pass.
`default_nettype none

module tbbp_alu
  import tbbp_pkg::*;
#(
  parameter int NUM_RATES = 16
) (
  input  wire logic                clk,
  input  wire alu_op_t             op,
  input  wire logic [RATE_W-1:0]   rate_max,
  input  wire logic [RATE_W-1:0]   rate_step,
  input  wire logic [TIME_W-1:0]   now,
  input  wire logic [TIME_W-1:0]   prev,
  input  wire logic [WORK_W-1:0]   work,
  input  wire logic [LVL_W-1:0]    level_in,
  input  wire logic [LVL_W-1:0]    peak_in,
  output logic      [LVL_W-1:0]    level_out,
  output logic      [LVL_W-1:0]    peak_out
);

  // Rate offset i*rate_step never needs more than this many bits.
  localparam int DEC_W = RATE_W + ((NUM_RATES > 1) ? $clog2(NUM_RATES) : 1);
  localparam int HI_W  = TIME_W - RATE_W;

  logic [TIME_W-1:0]      elapsed;
  logic [DEC_W-1:0]       dec;
  logic [RATE_W-1:0]      rate;
  logic [LVL_W-1:0]       prod;
  logic [RATE_W+HI_W-1:0] hi;
  logic [LVL_W-1:0]       amount;
  logic                   ovf;
  logic [LVL_W-1:0]       lvl;

  logic [LVL_W-1:0] add_a;
  logic [LVL_W-1:0] add_b;
  logic             add_sub;
  logic [LVL_W:0]   sum;
  logic             carry;
  logic [RATE_W-1:0] mul_b;
  logic [LVL_W-1:0]  mul_p;

  // Operand selection for the single 65-bit adder.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (op)
      OP_ELAPSED: begin
        add_a   = LVL_W'(now);
        add_b   = LVL_W'(prev);
        add_sub = 1'b1;
      end
      OP_RATE: begin
        add_a   = LVL_W'(rate_max);
        add_b   = LVL_W'(dec);
        add_sub = 1'b1;
      end
      OP_MUL_LO: begin
        add_a = LVL_W'(dec);
        add_b = LVL_W'(rate_step);
      end
      OP_AMOUNT: begin
        add_a = prod;
        add_b = {hi[RATE_W-1:0], {RATE_W{1'b0}}};
      end
      OP_DRAIN: begin
        add_a   = level_in;
        add_b   = amount;
        add_sub = 1'b1;
      end
      OP_FILL_PEAK: begin
        add_a = lvl;
        add_b = LVL_W'({work, {FRAC_W{1'b0}}});
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (LVL_W+1)'(add_sub);
  assign carry = sum[LVL_W];

  // One 32x32 multiplier; the 48-bit elapsed time goes through it in two halves.
  assign mul_b = (op == OP_MUL_HI) ? RATE_W'(elapsed[TIME_W-1:RATE_W]) : elapsed[RATE_W-1:0];
  assign mul_p = LVL_W'(rate) * LVL_W'(mul_b);

  // The fill and the peak compare share a cycle: the compare uses the filled
  // level directly, so it runs on its own comparator.
  logic [LVL_W-1:0] filled;
  assign filled    = carry ? '1 : sum[LVL_W-1:0];
  assign level_out = filled;
  assign peak_out  = (filled > peak_in) ? filled : peak_in;

  always_ff @(posedge clk) begin
    case (op)
      OP_ELAPSED: begin
        elapsed <= carry ? sum[TIME_W-1:0] : '0;
        dec     <= '0;
      end
      OP_RATE: begin
        rate <= (carry && (|sum[LVL_W-1:0])) ? sum[RATE_W-1:0] : '0;
      end
      OP_MUL_LO: begin
        prod <= mul_p;
        dec  <= sum[DEC_W-1:0];
      end
      OP_MUL_HI: begin
        hi <= mul_p[RATE_W+HI_W-1:0];
      end
      OP_AMOUNT: begin
        amount <= sum[LVL_W-1:0];
        ovf    <= carry | (|hi[RATE_W+HI_W-1:RATE_W]);
      end
      OP_DRAIN: begin
        lvl <= (ovf || !carry) ? '0 : sum[LVL_W-1:0];
      end
      default: begin
        lvl <= lvl;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/tbbp_mem.sv
// Bucket level and peak store with per-entry valid bits so a trace end clears it at once.
`default_nettype none

module tbbp_mem
  import tbbp_pkg::*;
#(
  parameter int NUM_RATES = 16,
  localparam int IDX_W = (NUM_RATES > 1) ? $clog2(NUM_RATES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mem_ctrl_t        ctrl,
  input  wire logic [IDX_W-1:0] addr,
  input  wire logic [LVL_W-1:0] wr_level,
  input  wire logic [LVL_W-1:0] wr_peak,
  output logic      [LVL_W-1:0] rd_level,
  output logic      [LVL_W-1:0] rd_peak
);

  logic [LVL_W-1:0]     level_mem [NUM_RATES];
  logic [LVL_W-1:0]     peak_mem  [NUM_RATES];
  logic [NUM_RATES-1:0] valid;
  logic [LVL_W-1:0]     level_q;
  logic [LVL_W-1:0]     peak_q;
  logic                 valid_q;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      level_mem[addr] <= wr_level;
      peak_mem[addr]  <= wr_peak;
    end
    if (ctrl.rd_en) begin
      level_q <= level_mem[addr];
      peak_q  <= peak_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        valid <= '0;
      end else if (ctrl.wr_en) begin
        valid[addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        valid_q <= valid[addr];
      end
    end
  end

  // An entry never written since the last clear reads as zero.
  assign rd_level = valid_q ? level_q : '0;
  assign rd_peak  = valid_q ? peak_q  : '0;

endmodule

`default_nettype wire

### hw/rtl/token_bucket_burst_profiler.sv
// Top level of the multi-rate token bucket burst profiler: registers, sequencer, result register.
`default_nettype none

// The profiler keeps one virtual token bucket per drain rate, where rate i is
// rate_max - i*rate_step (Q16.16, taken as zero once the offset reaches
// rate_max), for the first rate_count rates (0 acts as 1, values above
// NUM_RATES act as NUM_RATES). Each trace item drains every active bucket by
// rate times the ticks elapsed since the previous item (no drain if time went
// backwards, full drain if the product exceeds 64 bits), adds the item's work
// as Q48.16 with saturation, and raises that rate's peak. All buckets run
// through one shared unit: one 32x32 multiplier used twice and one 65-bit
// adder, under a sequencer that visits, for each active rate, the rate,
// multiply low and high, amount, drain and fill states; in_stall is high
// throughout. On an item with trace_end set, the block then reports one peak
// per active rate, in index order, with last_of_run on the final one; each
// result is read out of the store and waits in the output register while
// out_stall is high. The last result clears all buckets and peaks (the
// closing item zeroed the previous time), and the block takes the next item
// while that result still waits. The user must write configuration through
// cfg_wr_en, cfg_index and cfg_data only while the block is idle, which it
// does not enforce; indexes beyond rate_count are ignored.
module token_bucket_burst_profiler
  import tbbp_pkg::*;
#(
  parameter int NUM_RATES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [TIME_W-1:0]     arrival_time,
  input  wire logic [WORK_W-1:0]     work_amount,
  input  wire logic                  trace_end,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [RIDX_W-1:0]     rate_index,
  output logic      [LVL_W-1:0]      max_burst,
  output logic                       last_of_run,

  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_RATES > 1) ? $clog2(NUM_RATES) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ELAP,
    S_RATE,
    S_MLO,
    S_MHI,
    S_AMT,
    S_DRN,
    S_FILL,
    S_RD,
    S_SHOW
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  idx;
  logic [TIME_W-1:0] now;
  logic [WORK_W-1:0] work;
  logic              last;
  logic [TIME_W-1:0] prev_time;

  logic [RATE_W-1:0] rate_max;
  logic [RATE_W-1:0] rate_step;
  logic [CNT_W-1:0]  rate_count;

  logic [IDX_W-1:0]  last_idx;
  logic              idx_is_last;
  logic              out_free;
  logic              show_fire;
  alu_op_t           op;
  mem_ctrl_t         mem_ctrl;
  logic [LVL_W-1:0]  alu_level;
  logic [LVL_W-1:0]  alu_peak;
  logic [LVL_W-1:0]  mem_level;
  logic [LVL_W-1:0]  mem_peak;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_max   <= RATE_MAX_RST;
      rate_step  <= RATE_STEP_RST;
      rate_count <= RATE_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RATE_MAX:   rate_max   <= cfg_data[RATE_W-1:0];
        CFG_RATE_STEP:  rate_step  <= cfg_data[RATE_W-1:0];
        CFG_RATE_COUNT: rate_count <= cfg_data[CNT_W-1:0];
        default: begin
          rate_max <= rate_max;
        end
      endcase
    end
  end

  // Index of the final active rate after clamping the count to 1..NUM_RATES.
  always_comb begin
    if (rate_count == '0) begin
      last_idx = '0;
    end else if (32'(rate_count) > NUM_RATES) begin
      last_idx = IDX_W'(NUM_RATES - 1);
    end else begin
      last_idx = IDX_W'(rate_count - CNT_W'(1));
    end
  end

  assign idx_is_last = (idx == last_idx);
  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != S_IDLE);
  // A result moves into the output register in this cycle.
  assign show_fire   = (state == S_SHOW) && out_free;

  // Unit opcode and store control follow the sequencer state.
  always_comb begin
    op       = OP_NONE;
    mem_ctrl = '0;
    case (state)
      S_ELAP: op = OP_ELAPSED;
      S_RATE: begin
        op             = OP_RATE;
        mem_ctrl.rd_en = 1'b1;
      end
      S_MLO:  op = OP_MUL_LO;
      S_MHI:  op = OP_MUL_HI;
      S_AMT:  op = OP_AMOUNT;
      S_DRN:  op = OP_DRAIN;
      S_FILL: begin
        op             = OP_FILL_PEAK;
        mem_ctrl.wr_en = 1'b1;
      end
      S_RD:   mem_ctrl.rd_en = 1'b1;
      S_SHOW: mem_ctrl.clear = out_free && idx_is_last;
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      prev_time <= '0;
      out_valid <= 1'b0;
    end else begin
      if (show_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            now   <= arrival_time;
            work  <= work_amount;
            last  <= trace_end;
            state <= S_ELAP;
          end
        end
        S_ELAP: begin
          // The unit has latched the elapsed time; the previous time moves on,
          // or returns to zero when this item closes the trace.
          prev_time <= last ? '0 : now;
          idx       <= '0;
          state     <= S_RATE;
        end
        S_RATE: state <= S_MLO;
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_AMT;
        S_AMT:  state <= S_DRN;
        S_DRN:  state <= S_FILL;
        S_FILL: begin
          if (!idx_is_last) begin
            idx   <= idx + IDX_W'(1);
            state <= S_RATE;
          end else if (last) begin
            idx   <= '0;
            state <= S_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RD: state <= S_SHOW;
        S_SHOW: begin
          if (out_free) begin
            rate_index  <= RIDX_W'(idx);
            max_burst   <= mem_peak;
            last_of_run <= idx_is_last;
            if (idx_is_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tbbp_alu #(
    .NUM_RATES(NUM_RATES)
  ) u_alu (
    .clk       (clk),
    .op        (op),
    .rate_max  (rate_max),
    .rate_step (rate_step),
    .now       (now),
    .prev      (prev_time),
    .work      (work),
    .level_in  (mem_level),
    .peak_in   (mem_peak),
    .level_out (alu_level),
    .peak_out  (alu_peak)
  );

  tbbp_mem #(
    .NUM_RATES(NUM_RATES)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mem_ctrl),
    .addr     (idx),
    .wr_level (alu_level),
    .wr_peak  (alu_peak),
    .rd_level (mem_level),
    .rd_peak  (mem_peak)
  );

endmodule

`default_nettype wire

### sim/token_bucket_burst_profiler_tb.sv
// Self-checking testbench of the multi-rate token bucket burst profiler.
`timescale 1ns / 1ps

module token_bucket_burst_profiler_tb
  import tbbp_pkg::*;
();

  localparam int NUM_RATES = 16;

  // The package names only the three real registers. Index three exists on
  // the port but must be ignored by the block.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [TIME_W-1:0] TIME_TOP = '1;
  localparam logic [WORK_W-1:0] WORK_TOP = '1;
  localparam logic [RATE_W-1:0] RATE_TOP = '1;

  // One reported peak: the fields of a single result item.
  typedef struct {
    logic [RIDX_W-1:0] idx;
    logic [LVL_W-1:0]  burst;
    logic              last;
  } peak_report_t;

  // The scoreboard carries its own copy of the bucket state and the
  // configuration. Every accepted trace item is run through the bucket
  // arithmetic here, and a trace end turns the peaks into expected reports.
  class peak_scoreboard;
    logic [RATE_W-1:0] rate_max_q;
    logic [RATE_W-1:0] rate_step_q;
    logic [CNT_W-1:0]  count_q;
    logic [LVL_W-1:0]  level [NUM_RATES];
    logic [LVL_W-1:0]  peak [NUM_RATES];
    logic [TIME_W-1:0] prev_t;
    peak_report_t      expected_peaks [$];
    int                errors;

    function new();
      rate_max_q  = RATE_MAX_RST;
      rate_step_q = RATE_STEP_RST;
      count_q     = RATE_COUNT_RST;
      prev_t      = '0;
      errors      = 0;
      for (int i = 0; i < NUM_RATES; i++) begin
        level[i] = '0;
        peak[i]  = '0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_RATE_MAX:   rate_max_q = val[RATE_W-1:0];
        CFG_RATE_STEP:  rate_step_q = val[RATE_W-1:0];
        CFG_RATE_COUNT: count_q = val[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void absorb_entry(logic [TIME_W-1:0] now, logic [WORK_W-1:0] work, logic fin);
      logic [LVL_W-1:0]   work_q;
      logic [LVL_W-1:0]   lvl;
      logic [LVL_W-1:0]   dec;
      logic [LVL_W-1:0]   rate;
      logic [2*LVL_W-1:0] prod;
      logic [LVL_W:0]     sum;
      logic [TIME_W-1:0]  elapsed;
      peak_report_t       rep;
      int                 n;
      work_q  = {{(LVL_W-WORK_W-FRAC_W){1'b0}}, work, {FRAC_W{1'b0}}};
      // Time running backwards gives no drain at all.
      elapsed = (now >= prev_t) ? now - prev_t : '0;
      n = (count_q == 0) ? 1 : (count_q > NUM_RATES) ? NUM_RATES : int'(count_q);
      for (int i = 0; i < n; i++) begin
        dec  = LVL_W'(rate_step_q) * LVL_W'(i);
        rate = (dec >= LVL_W'(rate_max_q)) ? '0 : LVL_W'(rate_max_q) - dec;
        lvl  = level[i];
        if (rate != 0 && elapsed != 0) begin
          prod = (2*LVL_W)'(rate) * (2*LVL_W)'(elapsed);
          if (prod[2*LVL_W-1:LVL_W] != 0) lvl = '0;
          else lvl = (lvl > prod[LVL_W-1:0]) ? lvl - prod[LVL_W-1:0] : '0;
        end
        sum = {1'b0, lvl} + {1'b0, work_q};
        lvl = sum[LVL_W] ? '1 : sum[LVL_W-1:0];
        level[i] = lvl;
        if (lvl > peak[i]) peak[i] = lvl;
      end
      prev_t = now;
      if (fin) begin
        for (int i = 0; i < n; i++) begin
          rep.idx   = RIDX_W'(i);
          rep.burst = peak[i];
          rep.last  = (i == n - 1);
          expected_peaks.insert(expected_peaks.size(), rep);
        end
        for (int i = 0; i < NUM_RATES; i++) begin
          level[i] = '0;
          peak[i]  = '0;
        end
        prev_t = '0;
      end
    endfunction

    function void check_report(logic [RIDX_W-1:0] idx, logic [LVL_W-1:0] burst, logic last);
      peak_report_t want;
      if (expected_peaks.size() == 0) begin
        $error("unexpected result: rate_index %0d max_burst %0h", idx, burst);
        errors++;
        return;
      end
      want = expected_peaks.pop_front();
      if (idx !== want.idx) begin
        $error("rate_index: expected %0d, got %0d", want.idx, idx);
        errors++;
      end
      if (burst !== want.burst) begin
        $error("max_burst: expected %0h, got %0h", want.burst, burst);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [TIME_W-1:0]     arrival_time;
  logic [WORK_W-1:0]     work_amount;
  logic                  trace_end;
  logic                  out_valid;
  logic                  out_stall;
  logic [RIDX_W-1:0]     rate_index;
  logic [LVL_W-1:0]      max_burst;
  logic                  last_of_run;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  peak_scoreboard sb = new();

  // While a quiet flag is set, that side never idles, so the block also sees
  // long stretches of back-to-back traffic.
  bit in_quiet;
  bit out_quiet;
  int entries_sent;
  int stall_left;

  always #5 clk = ~clk;

  token_bucket_burst_profiler #(
    .NUM_RATES(NUM_RATES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .arrival_time(arrival_time),
    .work_amount(work_amount),
    .trace_end(trace_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rate_index(rate_index),
    .max_burst(max_burst),
    .last_of_run(last_of_run),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Presents one trace item and returns at the clock edge that accepts it.
  // The caller either presents the next item in the same step or lowers valid.
  task automatic send_entry(logic [TIME_W-1:0] t, logic [WORK_W-1:0] w, logic fin);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    arrival_time <= t;
    work_amount  <= w;
    trace_end    <= fin;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.absorb_entry(t, w, fin);
    entries_sent++;
  endtask

  // Writes one register; the write enable stays up for back-to-back writes.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task automatic program_rates(logic [RATE_W-1:0] rmax, logic [RATE_W-1:0] rstep,
                               logic [CFG_DATA_W-1:0] count_word);
    write_reg(CFG_RATE_MAX, rmax);
    write_reg(CFG_RATE_STEP, rstep);
    write_reg(CFG_RATE_COUNT, count_word);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits for every expected report and then for a full item's worth of
  // sequencer cycles, so that no item is still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_peaks.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // One random phase: a random setting, then a handful of traces. Traces are
  // mostly well formed, with timestamps that creep forward, but some jump far
  // ahead or step backwards.
  task automatic random_phase();
    logic [RATE_W-1:0]     rmax;
    logic [RATE_W-1:0]     rstep;
    logic [CFG_DATA_W-1:0] count_word;
    logic [TIME_W-1:0]     t;
    logic [WORK_W-1:0]     w;
    int                    traces;
    int                    len;
    int                    r;
    case ($urandom_range(0, 5))
      0: rmax = '0;
      1: rmax = RATE_TOP;
      2, 3: rmax = $urandom_range(1 << 14, 1 << 20);
      default: rmax = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: rstep = '0;
      1: rstep = RATE_TOP;
      2, 3: rstep = $urandom_range(0, 1 << 14);
      4: rstep = $urandom;
      default: rstep = rmax / $urandom_range(1, 16);
    endcase
    // The upper bits of the count word lie outside the register and must
    // not matter.
    count_word = $urandom & ~32'h1F;
    r = $urandom_range(0, 9);
    if (r == 0) count_word[CNT_W-1:0] = '0;
    else if (r == 1) count_word[CNT_W-1:0] = CNT_W'($urandom_range(NUM_RATES + 1, 31));
    else count_word[CNT_W-1:0] = CNT_W'($urandom_range(1, NUM_RATES));
    program_rates(rmax, rstep, count_word);
    in_quiet  = ($urandom_range(0, 4) == 0);
    out_quiet = ($urandom_range(0, 4) == 0);
    traces = $urandom_range(4, 10);
    for (int k = 0; k < traces; k++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
      case ($urandom_range(0, 3))
        0: t = '0;
        1: t = TIME_W'($urandom_range(0, 1000));
        2: t = TIME_W'({$urandom, $urandom});
        default: t = TIME_TOP - TIME_W'($urandom_range(0, 5000));
      endcase
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(0, 7))
          0: w = '0;
          1: w = WORK_TOP;
          2: w = $urandom;
          default: w = $urandom_range(0, 2000);
        endcase
        send_entry(t, w, j == len - 1);
        r = $urandom_range(0, 99);
        if (r < 85) t = t + TIME_W'($urandom_range(0, 300));
        else if (r < 90) t = t + TIME_W'({$urandom, $urandom});
        else if (r < 95) t = t - TIME_W'($urandom_range(0, 500));
      end
    end
  endtask

  // Receiver: checks each accepted report and stalls in random stretches.
  initial begin
    out_stall  <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_report(rate_index, max_burst, last_of_run);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap(out_quiet);
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    arrival_time <= '0;
    work_amount  <= '0;
    trace_end    <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= CFG_RATE_MAX;
    cfg_data     <= '0;
    entries_sent = 0;
    in_quiet     = 1'b0;
    out_quiet    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: sixteen rates near one unit per tick. Full work, then zero
    // work at the same time stamp (no elapsed time), a normal step forward, a step
    // backwards in time, and a trace end at the last representable tick.
    send_entry('0, WORK_TOP, 1'b0);
    send_entry('0, '0, 1'b0);
    send_entry(48'd100, 32'd1234, 1'b0);
    send_entry(48'd40, 32'd7, 1'b0);
    send_entry(TIME_TOP, WORK_TOP, 1'b1);
    wait_idle();

    // Highest rate with a step that makes rates from index eight on zero.
    // The jump to the last tick overflows the drain product for the high
    // rates, which empties their buckets. A count above the rate total acts
    // as the full set.
    program_rates(RATE_TOP, 32'h2000_0000, 32'd31);
    send_entry('0, WORK_TOP, 1'b0);
    send_entry(48'd1, 32'd5, 1'b0);
    send_entry(TIME_TOP, 32'd3, 1'b0);
    send_entry(TIME_TOP, '0, 1'b1);
    wait_idle();

    // All rates zero, and a count word whose register bits are zero, which
    // acts as one rate. A write to the unused index must change nothing.
    write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
    program_rates('0, '0, 32'hFFFF_FFE0);
    send_entry(48'd10, 32'd100, 1'b0);
    send_entry(48'd20, 32'd200, 1'b1);
    wait_idle();

    // A single rate with the smallest nonzero drain and a one-item trace.
    program_rates(32'd1, RATE_TOP, 32'd1);
    send_entry(48'd77, 32'd1, 1'b1);
    wait_idle();

    // Index eight lands exactly on rate_max, so rates from there on are zero.
    program_rates(32'd65536, 32'd8192, 32'd17);
    send_entry('0, 32'd1000, 1'b0);
    send_entry(48'd50, '0, 1'b0);
    send_entry(48'd100, 32'd10, 1'b1);
    wait_idle();

    entries_sent = 0;
    while (entries_sent < 460) begin
      random_phase();
      wait_idle();
    end

    if (sb.errors == 0 && sb.expected_peaks.size() == 0) begin
      $display("token_bucket_burst_profiler: match");
    end else begin
      $display("token_bucket_burst_profiler: mismatch");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #12ms;
    $display("token_bucket_burst_profiler: mismatch");
    $finish;
  end

endmodule

### token_bucket_burst_profiler.f
hw/rtl/tbbp_pkg.sv
hw/rtl/tbbp_alu.sv
hw/rtl/tbbp_mem.sv
hw/rtl/token_bucket_burst_profiler.sv
sim/token_bucket_burst_profiler_tb.sv
